FILE: hdl/dcsq_pkg.sv
// shared constants, codes and types of the dual class send queue scheduler
`timescale 1ns / 1ps
`default_nettype none
package dcsq_pkg;

  // handle and queue sizes
  localparam int HANDLE_BITS      = 16;
  localparam int RELIABLE_DEPTH   = 64;
  localparam int UNRELIABLE_DEPTH = 64;

  // derived widths
  localparam int RPTR_W  = (RELIABLE_DEPTH > 1) ? $clog2(RELIABLE_DEPTH) : 1;
  localparam int UPTR_W  = (UNRELIABLE_DEPTH > 1) ? $clog2(UNRELIABLE_DEPTH) : 1;
  localparam int RCNT_W  = $clog2(RELIABLE_DEPTH + 1);
  localparam int UCNT_W  = $clog2(UNRELIABLE_DEPTH + 1);
  localparam int LIMIT_W = 7;
  localparam int LIMX_W  = (UCNT_W > LIMIT_W) ? UCNT_W : LIMIT_W;
  localparam int QCNT_W  = 8;
  localparam int QSUM_W  = RCNT_W + UCNT_W + QCNT_W;
  localparam int OP_W    = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
  localparam logic [OP_W-1:0] OP_POP       = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_RES   = 3'd2;
  localparam logic [OP_W-1:0] OP_TAKE_RES  = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_RES  = 3'd4;

  // where a returned or dropped handle comes from
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_REL,
    SRC_UNR,
    SRC_REG
  } src_e;

  // result of one word, before the store read data joins it
  typedef struct packed {
    src_e                   out_src;
    logic                   out_unrel;
    logic [HANDLE_BITS-1:0] out_val;
    src_e                   drop_src;
    logic [HANDLE_BITS-1:0] drop_val;
    logic                   overflow;
    logic [QCNT_W-1:0]      qcount;
    logic                   nothing;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/dcsq_ram.sv
// generic single write, single read ram with registered read-first output
`timescale 1ns / 1ps
`default_nettype none
module dcsq_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/dcsq_core.sv
// queue pointers, reserved slot, class alternation and per-word decisions
`timescale 1ns / 1ps
`default_nettype none
module dcsq_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dcsq_pkg::LIMIT_W-1:0]     cfg_wdata_i,
  input  wire logic                            fire_i,
  input  wire logic [dcsq_pkg::OP_W-1:0]        op_i,
  input  wire logic [dcsq_pkg::HANDLE_BITS-1:0] handle_i,
  input  wire logic                            unrel_i,
  output logic                                 rel_we_o,
  output logic      [dcsq_pkg::RPTR_W-1:0]      rel_waddr_o,
  output logic                                 rel_re_o,
  output logic      [dcsq_pkg::RPTR_W-1:0]      rel_raddr_o,
  output logic                                 unr_we_o,
  output logic      [dcsq_pkg::UPTR_W-1:0]      unr_waddr_o,
  output logic                                 unr_re_o,
  output logic      [dcsq_pkg::UPTR_W-1:0]      unr_raddr_o,
  output dcsq_pkg::res_t                        res_o
);
  import dcsq_pkg::*;

  logic [LIMIT_W-1:0]     limit_q;
  logic [RPTR_W-1:0]      rel_head_q, rel_head_d, rel_tail_q, rel_tail_d;
  logic [RCNT_W-1:0]      rel_cnt_q, rel_cnt_d;
  logic [UPTR_W-1:0]      unr_head_q, unr_head_d, unr_tail_q, unr_tail_d;
  logic [UCNT_W-1:0]      unr_cnt_q, unr_cnt_d;
  logic                   rsv_valid_q, rsv_valid_d;
  logic                   rsv_unrel_q, rsv_unrel_d;
  logic [HANDLE_BITS-1:0] rsv_handle_q, rsv_handle_d;
  logic                   prefer_q, prefer_d;
  logic [LIMX_W-1:0]      limit_ext;
  logic [UCNT_W-1:0]      lim;
  logic                   has_rsv;
  logic                   unr_at_limit;
  logic [QSUM_W-1:0]      qsum;

  // pointer step with wrap
  function automatic logic [RPTR_W-1:0] rel_next(input logic [RPTR_W-1:0] p);
    rel_next = (p == RPTR_W'(RELIABLE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [UPTR_W-1:0] unr_next(input logic [UPTR_W-1:0] p);
    unr_next = (p == UPTR_W'(UNRELIABLE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // effective limit: zero acts as one, clipped to the store depth
  always_comb begin
    limit_ext = LIMX_W'(limit_q);
    if (limit_ext == '0) begin
      lim = UCNT_W'(1);
    end else if (limit_ext > LIMX_W'(UNRELIABLE_DEPTH)) begin
      lim = UCNT_W'(UNRELIABLE_DEPTH);
    end else begin
      lim = UCNT_W'(limit_ext);
    end
  end

  assign has_rsv      = rsv_valid_q && rsv_unrel_q;
  assign unr_at_limit = unr_cnt_q >= lim;

  // store addresses follow the pointers
  assign rel_waddr_o = rel_tail_q;
  assign rel_raddr_o = rel_head_q;
  assign unr_waddr_o = unr_tail_q;
  assign unr_raddr_o = unr_head_q;

  // word decode and next state
  always_comb begin
    rel_head_d   = rel_head_q;
    rel_tail_d   = rel_tail_q;
    rel_cnt_d    = rel_cnt_q;
    unr_head_d   = unr_head_q;
    unr_tail_d   = unr_tail_q;
    unr_cnt_d    = unr_cnt_q;
    rsv_valid_d  = rsv_valid_q;
    rsv_unrel_d  = rsv_unrel_q;
    rsv_handle_d = rsv_handle_q;
    prefer_d     = prefer_q;
    rel_we_o     = 1'b0;
    rel_re_o     = 1'b0;
    unr_we_o     = 1'b0;
    unr_re_o     = 1'b0;
    res_o        = '0;
    res_o.out_src  = SRC_NONE;
    res_o.drop_src = SRC_NONE;

    if (fire_i) begin
      unique case (op_i) inside
        OP_PUSH: begin
          if (unrel_i) begin
            // make room when the class is at its limit
            if ((UCNT_W + 1)'(unr_cnt_q) + (UCNT_W + 1)'(has_rsv) >=
                (UCNT_W + 1)'(lim)) begin
              if (has_rsv && (unr_cnt_q < UCNT_W'(UNRELIABLE_DEPTH))) begin
                res_o.drop_src = SRC_REG;
                res_o.drop_val = rsv_handle_q;
                rsv_valid_d    = 1'b0;
                rsv_unrel_d    = 1'b0;
                rsv_handle_d   = '0;
              end else if (unr_cnt_q != '0) begin
                res_o.drop_src = SRC_UNR;
                unr_re_o       = 1'b1;
                unr_head_d     = unr_next(unr_head_q);
                unr_cnt_d      = unr_cnt_q - 1'b1;
              end
            end
            unr_we_o   = 1'b1;
            unr_tail_d = unr_next(unr_tail_q);
            unr_cnt_d  = unr_cnt_d + 1'b1;
          end else if (rel_cnt_q >= RCNT_W'(RELIABLE_DEPTH)) begin
            res_o.overflow = 1'b1;
            res_o.drop_src = SRC_REG;
            res_o.drop_val = handle_i;
          end else begin
            rel_we_o   = 1'b1;
            rel_tail_d = rel_next(rel_tail_q);
            rel_cnt_d  = rel_cnt_q + 1'b1;
          end
        end
        OP_POP: begin
          // alternate classes, unreliable whenever reliable is empty
          if ((unr_cnt_q != '0) && (prefer_q || (rel_cnt_q == '0))) begin
            res_o.out_src   = SRC_UNR;
            res_o.out_unrel = 1'b1;
            unr_re_o        = 1'b1;
            unr_head_d      = unr_next(unr_head_q);
            unr_cnt_d       = unr_cnt_q - 1'b1;
            prefer_d        = 1'b0;
          end else if (rel_cnt_q != '0) begin
            res_o.out_src = SRC_REL;
            rel_re_o      = 1'b1;
            rel_head_d    = rel_next(rel_head_q);
            rel_cnt_d     = rel_cnt_q - 1'b1;
            prefer_d      = 1'b1;
          end
        end
        OP_SET_RES: begin
          if (unrel_i && unr_at_limit) begin
            res_o.drop_src = SRC_REG;
            res_o.drop_val = handle_i;
          end else begin
            if (rsv_valid_q) begin
              res_o.drop_src = SRC_REG;
              res_o.drop_val = rsv_handle_q;
            end
            rsv_valid_d  = 1'b1;
            rsv_unrel_d  = unrel_i;
            rsv_handle_d = handle_i;
          end
        end
        OP_TAKE_RES, OP_PEEK_RES: begin
          if (rsv_valid_q) begin
            res_o.out_src   = SRC_REG;
            res_o.out_val   = rsv_handle_q;
            res_o.out_unrel = rsv_unrel_q;
            if (op_i == OP_TAKE_RES) begin
              rsv_valid_d  = 1'b0;
              rsv_unrel_d  = 1'b0;
              rsv_handle_d = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // status after the word
    qsum          = QSUM_W'(rel_cnt_d) + QSUM_W'(unr_cnt_d);
    res_o.qcount  = qsum[QCNT_W-1:0];
    res_o.nothing = (rel_cnt_d == '0) && (unr_cnt_d == '0) && !rsv_valid_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_head_q   <= '0;
      rel_tail_q   <= '0;
      rel_cnt_q    <= '0;
      unr_head_q   <= '0;
      unr_tail_q   <= '0;
      unr_cnt_q    <= '0;
      rsv_valid_q  <= 1'b0;
      rsv_unrel_q  <= 1'b0;
      rsv_handle_q <= '0;
      prefer_q     <= 1'b0;
    end else begin
      rel_head_q   <= rel_head_d;
      rel_tail_q   <= rel_tail_d;
      rel_cnt_q    <= rel_cnt_d;
      unr_head_q   <= unr_head_d;
      unr_tail_q   <= unr_tail_d;
      unr_cnt_q    <= unr_cnt_d;
      rsv_valid_q  <= rsv_valid_d;
      rsv_unrel_q  <= rsv_unrel_d;
      rsv_handle_q <= rsv_handle_d;
      prefer_q     <= prefer_d;
    end
  end

`ifndef NO_ASSERTIONS
  // counts never pass the store depths
  a_rel_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_cnt_q <= RCNT_W'(RELIABLE_DEPTH))
    else $error("reliable count beyond depth");

  a_unr_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unr_cnt_q <= UCNT_W'(UNRELIABLE_DEPTH))
    else $error("unreliable count beyond depth");

  // pointers meet whenever a queue is empty or full
  a_rel_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((rel_cnt_q == '0) || (rel_cnt_q == RCNT_W'(RELIABLE_DEPTH))) |->
      (rel_head_q == rel_tail_q))
    else $error("reliable pointers out of step with count");

  a_unr_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((unr_cnt_q == '0) || (unr_cnt_q == UCNT_W'(UNRELIABLE_DEPTH))) |->
      (unr_head_q == unr_tail_q))
    else $error("unreliable pointers out of step with count");

  // reserved class flag only with an occupied slot
  a_rsv_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsv_unrel_q |-> rsv_valid_q)
    else $error("reserved class set on an empty slot");
`endif

endmodule
`default_nettype wire

FILE: hdl/dcsq_out.sv
// result register, joins the store read data to the registered decision
`timescale 1ns / 1ps
`default_nettype none
module dcsq_out (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire logic                            ready_i,
  input  dcsq_pkg::res_t                        res_i,
  input  wire logic [dcsq_pkg::HANDLE_BITS-1:0] rel_rdata_i,
  input  wire logic [dcsq_pkg::HANDLE_BITS-1:0] unr_rdata_i,
  output logic                                 valid_o,
  output logic                                 out_valid_o,
  output logic      [dcsq_pkg::HANDLE_BITS-1:0] out_handle_o,
  output logic                                 out_unreliable_o,
  output logic                                 dropped_valid_o,
  output logic      [dcsq_pkg::HANDLE_BITS-1:0] dropped_handle_o,
  output logic                                 overflow_o,
  output logic      [dcsq_pkg::QCNT_W-1:0]      queued_count_o,
  output logic                                 nothing_to_send_o
);
  import dcsq_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // valid flag
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // decision payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  // handle selection
  always_comb begin
    case (res_q.out_src)
      SRC_REL: out_handle_o = rel_rdata_i;
      SRC_UNR: out_handle_o = unr_rdata_i;
      SRC_REG: out_handle_o = res_q.out_val;
      default: out_handle_o = '0;
    endcase
    case (res_q.drop_src)
      SRC_REL: dropped_handle_o = rel_rdata_i;
      SRC_UNR: dropped_handle_o = unr_rdata_i;
      SRC_REG: dropped_handle_o = res_q.drop_val;
      default: dropped_handle_o = '0;
    endcase
  end

  assign valid_o           = valid_q;
  assign out_valid_o       = res_q.out_src != SRC_NONE;
  assign out_unreliable_o  = res_q.out_unrel;
  assign dropped_valid_o   = res_q.drop_src != SRC_NONE;
  assign overflow_o        = res_q.overflow;
  assign queued_count_o    = res_q.qcount;
  assign nothing_to_send_o = res_q.nothing;

endmodule
`default_nettype wire

FILE: hdl/dual_class_send_queue_scheduler_unit.sv
// top level of the dual class send queue scheduler
//
//   channel   direction  handshake                     word
//   item      in         item_valid_i / item_ready_o    operation, handle, class
//   result    out        result_valid_o / result_ready_i  returned, dropped, status
//   cfg       in         cfg_we_i                       unreliable limit
//
// a word is taken into the input register, decided there against the queue
// pointers and the reserved slot, and lands in the result register together
// with the registered store read: one word per cycle sustained while the
// result channel does not stall. the store ports (one write, one read per
// queue) set that rate. reset empties both queues and the reserved slot at
// once, no clearing pass. a stalled result holds the input register, which
// holds the item side.
`timescale 1ns / 1ps
`default_nettype none
module dual_class_send_queue_scheduler_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dcsq_pkg::LIMIT_W-1:0]     cfg_wdata_i,
  input  wire logic                            item_valid_i,
  output logic                                 item_ready_o,
  input  wire logic [dcsq_pkg::OP_W-1:0]        operation_i,
  input  wire logic [dcsq_pkg::HANDLE_BITS-1:0] packet_handle_i,
  input  wire logic                            is_unreliable_i,
  output logic                                 result_valid_o,
  input  wire logic                            result_ready_i,
  output logic                                 out_valid_o,
  output logic      [dcsq_pkg::HANDLE_BITS-1:0] out_handle_o,
  output logic                                 out_unreliable_o,
  output logic                                 dropped_valid_o,
  output logic      [dcsq_pkg::HANDLE_BITS-1:0] dropped_handle_o,
  output logic                                 overflow_o,
  output logic      [dcsq_pkg::QCNT_W-1:0]      queued_count_o,
  output logic                                 nothing_to_send_o
);
  import dcsq_pkg::*;

  logic                   in_valid_q;
  logic [OP_W-1:0]        in_op_q;
  logic [HANDLE_BITS-1:0] in_handle_q;
  logic                   in_unrel_q;
  logic                   fire;
  logic                   item_take;
  logic                   rel_we, rel_re, unr_we, unr_re;
  logic [RPTR_W-1:0]      rel_waddr, rel_raddr;
  logic [UPTR_W-1:0]      unr_waddr, unr_raddr;
  logic [HANDLE_BITS-1:0] rel_rdata, unr_rdata;
  res_t                   res;

  // input register moves on when the result register has room
  assign fire         = in_valid_q && (!result_valid_o || result_ready_i);
  assign item_ready_o = !in_valid_q || fire;
  assign item_take    = item_valid_i && item_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      in_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take) begin
      in_op_q     <= operation_i;
      in_handle_q <= packet_handle_i;
      in_unrel_q  <= is_unreliable_i;
    end
  end

  // scheduler state and decisions
  dcsq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .op_i        (in_op_q),
    .handle_i    (in_handle_q),
    .unrel_i     (in_unrel_q),
    .rel_we_o    (rel_we),
    .rel_waddr_o (rel_waddr),
    .rel_re_o    (rel_re),
    .rel_raddr_o (rel_raddr),
    .unr_we_o    (unr_we),
    .unr_waddr_o (unr_waddr),
    .unr_re_o    (unr_re),
    .unr_raddr_o (unr_raddr),
    .res_o       (res)
  );

  // handle stores
  dcsq_ram #(
    .Width (HANDLE_BITS),
    .Depth (RELIABLE_DEPTH)
  ) u_rel_ram (
    .clk_i   (clk_i),
    .we_i    (rel_we),
    .waddr_i (rel_waddr),
    .wdata_i (in_handle_q),
    .re_i    (rel_re),
    .raddr_i (rel_raddr),
    .rdata_o (rel_rdata)
  );

  dcsq_ram #(
    .Width (HANDLE_BITS),
    .Depth (UNRELIABLE_DEPTH)
  ) u_unr_ram (
    .clk_i   (clk_i),
    .we_i    (unr_we),
    .waddr_i (unr_waddr),
    .wdata_i (in_handle_q),
    .re_i    (unr_re),
    .raddr_i (unr_raddr),
    .rdata_o (unr_rdata)
  );

  // result register
  dcsq_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (fire),
    .ready_i           (result_ready_i),
    .res_i             (res),
    .rel_rdata_i       (rel_rdata),
    .unr_rdata_i       (unr_rdata),
    .valid_o           (result_valid_o),
    .out_valid_o       (out_valid_o),
    .out_handle_o      (out_handle_o),
    .out_unreliable_o  (out_unreliable_o),
    .dropped_valid_o   (dropped_valid_o),
    .dropped_handle_o  (dropped_handle_o),
    .overflow_o        (overflow_o),
    .queued_count_o    (queued_count_o),
    .nothing_to_send_o (nothing_to_send_o)
  );

endmodule
`default_nettype wire

FILE: test/dcsq_schedule_monitor.sv
// monitor that predicts every scheduler result word and compares it on the result channel
`timescale 1ns / 1ps
module dcsq_schedule_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dcsq_pkg::LIMIT_W-1:0]     cfg_wdata_i,
  input  logic                             item_valid_i,
  input  logic                             item_ready_i,
  input  logic [dcsq_pkg::OP_W-1:0]        operation_i,
  input  logic [dcsq_pkg::HANDLE_BITS-1:0] packet_handle_i,
  input  logic                             is_unreliable_i,
  input  logic                             result_valid_i,
  input  logic                             result_ready_i,
  input  logic                             out_valid_i,
  input  logic [dcsq_pkg::HANDLE_BITS-1:0] out_handle_i,
  input  logic                             out_unreliable_i,
  input  logic                             dropped_valid_i,
  input  logic [dcsq_pkg::HANDLE_BITS-1:0] dropped_handle_i,
  input  logic                             overflow_i,
  input  logic [dcsq_pkg::QCNT_W-1:0]      queued_count_i,
  input  logic                             nothing_to_send_i,
  output int                               mismatches_o,
  output int                               words_pending_o
);
  import dcsq_pkg::*;

  // one result word as the block should return it
  typedef struct {
    logic                   out_valid;
    logic [HANDLE_BITS-1:0] out_handle;
    logic                   out_unrel;
    logic                   drop_valid;
    logic [HANDLE_BITS-1:0] drop_handle;
    logic                   overflow;
    logic [QCNT_W-1:0]      queued;
    logic                   nothing;
  } sched_word_t;

  // predicted queue state
  logic [HANDLE_BITS-1:0] rel_mem [RELIABLE_DEPTH];
  logic [HANDLE_BITS-1:0] unr_mem [UNRELIABLE_DEPTH];
  int                     rel_head, rel_cnt;
  int                     unr_head, unr_cnt;
  logic                   resv_valid, resv_unrel;
  logic [HANDLE_BITS-1:0] resv_handle;
  logic                   prefer_unrel;
  logic [LIMIT_W-1:0]     limit_q;

  sched_word_t            expected_words [$];
  int                     mismatches;
  int                     word_index;

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    $display("%0t: word %0d %s: expected %0h, got %0h", $time, word_index, what, want, got);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) flag_mismatch(what, want, got);
  endtask

  function automatic logic [HANDLE_BITS-1:0] unr_take();
    logic [HANDLE_BITS-1:0] h;
    h = unr_mem[unr_head];
    unr_head = (unr_head + 1) % UNRELIABLE_DEPTH;
    unr_cnt--;
    return h;
  endfunction

  function automatic logic [HANDLE_BITS-1:0] rel_take();
    logic [HANDLE_BITS-1:0] h;
    h = rel_mem[rel_head];
    rel_head = (rel_head + 1) % RELIABLE_DEPTH;
    rel_cnt--;
    return h;
  endfunction

  function automatic void clear_reserved();
    resv_valid  = 1'b0;
    resv_unrel  = 1'b0;
    resv_handle = '0;
  endfunction

  // apply one operation to the predicted state and build its result word
  task automatic schedule_word(input logic [OP_W-1:0] op, input logic [HANDLE_BITS-1:0] h,
                               input logic u, output sched_word_t w);
    int   lim;
    logic has_res;
    w = '{default: '0};
    // a zero limit acts as one, anything above the depth as the depth
    lim = int'(limit_q);
    if (lim == 0) lim = 1;
    if (lim > UNRELIABLE_DEPTH) lim = UNRELIABLE_DEPTH;
    case (op) inside
      OP_PUSH: begin
        if (u) begin
          // at the limit: drop an unreliable reserved handle, else the oldest queued
          has_res = resv_valid && resv_unrel;
          if (unr_cnt + int'(has_res) >= lim) begin
            if (has_res && unr_cnt < UNRELIABLE_DEPTH) begin
              w.drop_valid  = 1'b1;
              w.drop_handle = resv_handle;
              clear_reserved();
            end else if (unr_cnt > 0) begin
              w.drop_valid  = 1'b1;
              w.drop_handle = unr_take();
            end
          end
          unr_mem[(unr_head + unr_cnt) % UNRELIABLE_DEPTH] = h;
          unr_cnt++;
        end else if (rel_cnt >= RELIABLE_DEPTH) begin
          w.overflow    = 1'b1;
          w.drop_valid  = 1'b1;
          w.drop_handle = h;
        end else begin
          rel_mem[(rel_head + rel_cnt) % RELIABLE_DEPTH] = h;
          rel_cnt++;
        end
      end
      OP_POP: begin
        // alternate classes, unreliable whenever reliable is empty
        if (unr_cnt > 0 && (prefer_unrel || rel_cnt == 0)) begin
          w.out_valid  = 1'b1;
          w.out_unrel  = 1'b1;
          w.out_handle = unr_take();
          prefer_unrel = 1'b0;
        end else if (rel_cnt > 0) begin
          w.out_valid  = 1'b1;
          w.out_handle = rel_take();
          prefer_unrel = 1'b1;
        end
      end
      OP_SET_RES: begin
        if (u && unr_cnt >= lim) begin
          // refused, the slot keeps its content
          w.drop_valid  = 1'b1;
          w.drop_handle = h;
        end else begin
          if (resv_valid) begin
            w.drop_valid  = 1'b1;
            w.drop_handle = resv_handle;
          end
          resv_valid  = 1'b1;
          resv_unrel  = u;
          resv_handle = h;
        end
      end
      OP_TAKE_RES, OP_PEEK_RES: begin
        if (resv_valid) begin
          w.out_valid  = 1'b1;
          w.out_handle = resv_handle;
          w.out_unrel  = resv_unrel;
          if (op == OP_TAKE_RES) clear_reserved();
        end
      end
      default: ;
    endcase
    w.queued  = QCNT_W'(rel_cnt + unr_cnt);
    w.nothing = (rel_cnt == 0) && (unr_cnt == 0) && !resv_valid;
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    sched_word_t want;
    if (!rst_ni) begin
      rel_head     = 0;
      rel_cnt      = 0;
      unr_head     = 0;
      unr_cnt      = 0;
      prefer_unrel = 1'b0;
      limit_q      = LIMIT_RESET;
      clear_reserved();
      expected_words.delete();
      mismatches      = 0;
      word_index      = 0;
      mismatches_o    <= 0;
      words_pending_o <= 0;
    end else begin
      if (result_valid_i && result_ready_i) begin
        if (expected_words.size() == 0) begin
          flag_mismatch("word with none expected, out_handle", '0, out_handle_i);
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          check_field("out_valid", want.out_valid, out_valid_i);
          check_field("out_handle", want.out_handle, out_handle_i);
          check_field("out_unreliable", want.out_unrel, out_unreliable_i);
          check_field("dropped_valid", want.drop_valid, dropped_valid_i);
          check_field("dropped_handle", want.drop_handle, dropped_handle_i);
          check_field("overflow", want.overflow, overflow_i);
          check_field("queued_count", want.queued, queued_count_i);
          check_field("nothing_to_send", want.nothing, nothing_to_send_i);
        end
        word_index++;
      end
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (item_valid_i && item_ready_i) begin
        schedule_word(operation_i, packet_handle_i, is_unreliable_i, want);
        expected_words.insert(expected_words.size(), want);
      end
      mismatches_o    <= mismatches;
      words_pending_o <= expected_words.size();
    end
  end

endmodule

FILE: test/dual_class_send_queue_scheduler_unit_test.sv
// testbench top: stimulus, receiver stalls, watchdog and verdict for the scheduler
`timescale 1ns / 1ps
module dual_class_send_queue_scheduler_unit_test;
  import dcsq_pkg::*;

  localparam int RANDOM_WORDS    = 1900;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int LIMIT_MAX       = (1 << LIMIT_W) - 1;
  localparam int OP_MAX          = (1 << OP_W) - 1;

  // operation mix of one random phase
  typedef enum int {
    MIX_FILL_UNR,
    MIX_FILL_REL,
    MIX_BALANCED,
    MIX_RESERVED,
    MIX_DRAIN
  } mix_e;

  // receiver behavior
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_e;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [LIMIT_W-1:0]     cfg_wdata;
  logic                   item_valid;
  logic                   item_ready;
  logic [OP_W-1:0]        operation;
  logic [HANDLE_BITS-1:0] packet_handle;
  logic                   is_unreliable;
  logic                   result_valid;
  logic                   result_ready;
  logic                   out_valid;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   out_unreliable;
  logic                   dropped_valid;
  logic [HANDLE_BITS-1:0] dropped_handle;
  logic                   overflow;
  logic [QCNT_W-1:0]      queued_count;
  logic                   nothing_to_send;

  int     mismatches;
  int     pending;
  int     words_sent;
  int     burst_left;
  int     quiet_cycles;
  stall_e stall_mode;
  int     mode_left;
  int     stall_left;

  dual_class_send_queue_scheduler_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .item_valid_i      (item_valid),
    .item_ready_o      (item_ready),
    .operation_i       (operation),
    .packet_handle_i   (packet_handle),
    .is_unreliable_i   (is_unreliable),
    .result_valid_o    (result_valid),
    .result_ready_i    (result_ready),
    .out_valid_o       (out_valid),
    .out_handle_o      (out_handle),
    .out_unreliable_o  (out_unreliable),
    .dropped_valid_o   (dropped_valid),
    .dropped_handle_o  (dropped_handle),
    .overflow_o        (overflow),
    .queued_count_o    (queued_count),
    .nothing_to_send_o (nothing_to_send)
  );

  dcsq_schedule_monitor monitor (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .item_valid_i      (item_valid),
    .item_ready_i      (item_ready),
    .operation_i       (operation),
    .packet_handle_i   (packet_handle),
    .is_unreliable_i   (is_unreliable),
    .result_valid_i    (result_valid),
    .result_ready_i    (result_ready),
    .out_valid_i       (out_valid),
    .out_handle_i      (out_handle),
    .out_unreliable_i  (out_unreliable),
    .dropped_valid_i   (dropped_valid),
    .dropped_handle_i  (dropped_handle),
    .overflow_i        (overflow),
    .queued_count_i    (queued_count),
    .nothing_to_send_i (nothing_to_send),
    .mismatches_o      (mismatches),
    .words_pending_o   (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls, switching between modes of random length
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      result_ready <= 1'b0;
      stall_mode   <= STALL_NONE;
      mode_left    <= 0;
      stall_left   <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  result_ready <= 1'b1;
        STALL_LIGHT: result_ready <= ($urandom_range(0, 3) != 0);
        STALL_HEAVY: result_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_left > 0) begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
          end else begin
            result_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 16);
          end
        end
      endcase
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // offer one word, with bursts and gaps on the sender side
  task automatic send_word(input logic [OP_W-1:0] op, input logic [HANDLE_BITS-1:0] h,
                           input logic u);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    item_valid    <= 1'b1;
    operation     <= op;
    packet_handle <= h;
    is_unreliable <= u;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    words_sent++;
  endtask

  // wait until every expected word has come back, then let the pipe settle
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    item_valid <= 1'b0;
    burst_left = 0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly random handles, sometimes the extremes
  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return HANDLE_BITS'($urandom);
    endcase
  endfunction

  // draw one word from the operation mix of a phase
  task automatic choose_word(input mix_e mix, output logic [OP_W-1:0] op,
                             output logic [HANDLE_BITS-1:0] h, output logic u);
    int push_w, pop_w, set_w, resv_w, unrel_pct, roll;
    case (mix)
      MIX_FILL_UNR: begin push_w = 75; pop_w = 8;  set_w = 8;  resv_w = 5;  unrel_pct = 95; end
      MIX_FILL_REL: begin push_w = 80; pop_w = 8;  set_w = 5;  resv_w = 4;  unrel_pct = 10; end
      MIX_BALANCED: begin push_w = 42; pop_w = 38; set_w = 8;  resv_w = 8;  unrel_pct = 50; end
      MIX_RESERVED: begin push_w = 30; pop_w = 15; set_w = 30; resv_w = 22; unrel_pct = 70; end
      default:      begin push_w = 15; pop_w = 70; set_w = 5;  resv_w = 6;  unrel_pct = 50; end
    endcase
    roll = $urandom_range(0, 99);
    h    = pick_handle();
    u    = 1'($urandom_range(0, 1));
    if (roll < push_w) begin
      op = OP_PUSH;
      u  = ($urandom_range(0, 99) < unrel_pct);
    end else if (roll < push_w + pop_w) begin
      op = OP_POP;
    end else if (roll < push_w + pop_w + set_w) begin
      op = OP_SET_RES;
    end else if (roll < push_w + pop_w + set_w + resv_w) begin
      op = $urandom_range(0, 1) ? OP_TAKE_RES : OP_PEEK_RES;
    end else begin
      op = OP_W'($urandom_range(int'(OP_PEEK_RES) + 1, OP_MAX));
    end
  endtask

  // stimulus and verdict
  initial begin
    int                     limit_plan [8];
    int                     phase, len, random_start, lim;
    mix_e                   mix;
    logic [OP_W-1:0]        op;
    logic [HANDLE_BITS-1:0] h;
    logic                   u;

    limit_plan    = '{64, 0, LIMIT_MAX, 2, 100, 1, 33, 64};
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    item_valid    <= 1'b0;
    operation     <= OP_PUSH;
    packet_handle <= '0;
    is_unreliable <= 1'b0;
    words_sent = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty block: nothing to return, then the unknown codes
    send_word(OP_POP, '0, 1'b0);
    send_word(OP_TAKE_RES, '1, 1'b1);
    send_word(OP_PEEK_RES, '0, 1'b1);
    for (int k = int'(OP_PEEK_RES) + 1; k <= OP_MAX; k++) send_word(OP_W'(k), '1, 1'b1);

    // both classes, reserved slot overwrite, peek then take, pop alternation
    send_word(OP_PUSH, '0, 1'b0);
    send_word(OP_PUSH, '1, 1'b1);
    send_word(OP_PUSH, '1, 1'b0);
    send_word(OP_PUSH, '0, 1'b1);
    send_word(OP_SET_RES, 16'h5a5a, 1'b1);
    send_word(OP_SET_RES, 16'ha5a5, 1'b0);
    send_word(OP_PEEK_RES, '0, 1'b0);
    send_word(OP_TAKE_RES, '0, 1'b0);
    send_word(OP_TAKE_RES, '0, 1'b0);
    repeat (5) send_word(OP_POP, '0, 1'b0);

    // limit of one: drop oldest, refused set, reserved handle dropped by a push
    write_limit(LIMIT_W'(1));
    send_word(OP_PUSH, 16'h1111, 1'b1);
    send_word(OP_PUSH, 16'h2222, 1'b1);
    send_word(OP_SET_RES, 16'h3333, 1'b1);
    send_word(OP_SET_RES, 16'h4444, 1'b0);
    send_word(OP_POP, '0, 1'b0);
    send_word(OP_SET_RES, 16'h5555, 1'b1);
    send_word(OP_PUSH, 16'h6666, 1'b1);
    send_word(OP_TAKE_RES, '0, 1'b0);
    send_word(OP_POP, '0, 1'b0);

    // random phases, each with its own limit and operation mix
    random_start = words_sent;
    phase = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      lim = (phase < $size(limit_plan)) ? limit_plan[phase] : $urandom_range(0, LIMIT_MAX);
      write_limit(LIMIT_W'(lim));
      mix = mix_e'(phase % mix.num());
      len = $urandom_range(100, 180);
      repeat (len) begin
        choose_word(mix, op, h, u);
        send_word(op, h, u);
      end
      phase++;
    end

    item_valid <= 1'b0;
    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
